[rtl/wvva_pkg.sv]
// Shared types, constants and tables for the wind vane vector averager.
// Depends on nothing.
package wvva_pkg;
  localparam int SUM_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int SECTORS = 16;
  localparam int STEPS = 16;
  localparam int SEC_BITS = 4;
  localparam int STEP_BITS = 4;
  // CORDIC datapath: normalized to 2^46, growth about 1.65, plus guard bit
  localparam int CW = 50;
  localparam int NORM_EXP = 46;

  // action field codes
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  typedef logic signed [SUM_BITS-1:0] sum_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic signed [CW-1:0] cw_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_ROT, ST_SCALE, ST_OUT
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [SEC_BITS-1:0] sector;
  } decode_t;

  function automatic decode_t decode_vane(input logic [11:0] raw);
    decode_t d;
    d.hit = 1'b1;
    d.sector = '0;
    if (raw >= 12'd3570 && raw < 12'd3700) d.sector = 4'd0;
    else if (raw >= 12'd2600 && raw < 12'd2700) d.sector = 4'd1;
    else if (raw >= 12'd2750 && raw < 12'd2850) d.sector = 4'd2;
    else if (raw >= 12'd1510 && raw < 12'd1580) d.sector = 4'd3;
    else if (raw >= 12'd1580 && raw < 12'd1650) d.sector = 4'd4;
    else if (raw >= 12'd1470 && raw < 12'd1510) d.sector = 4'd5;
    else if (raw >= 12'd1900 && raw < 12'd2000) d.sector = 4'd6;
    else if (raw >= 12'd1700 && raw < 12'd1750) d.sector = 4'd7;
    else if (raw >= 12'd2200 && raw < 12'd2400) d.sector = 4'd8;
    else if (raw >= 12'd2100 && raw < 12'd2200) d.sector = 4'd9;
    else if (raw >= 12'd3200 && raw < 12'd3299) d.sector = 4'd10;
    else if (raw >= 12'd3100 && raw < 12'd3200) d.sector = 4'd11;
    else if (raw >= 12'd3890 && raw < 12'd3999) d.sector = 4'd12;
    else if (raw >= 12'd3700 && raw < 12'd3780) d.sector = 4'd13;
    else if (raw >= 12'd3780 && raw < 12'd3890) d.sector = 4'd14;
    else if (raw >= 12'd3400 && raw < 12'd3500) d.sector = 4'd15;
    else d.hit = 1'b0;
    return d;
  endfunction

  function automatic logic signed [15:0] cos_q14(input logic [SEC_BITS-1:0] k);
    case (k)
      4'd0: cos_q14 = 16'sd16384;
      4'd1, 4'd15: cos_q14 = 16'sd15137;
      4'd2, 4'd14: cos_q14 = 16'sd11585;
      4'd3, 4'd13: cos_q14 = 16'sd6270;
      4'd5, 4'd11: cos_q14 = -16'sd6270;
      4'd6, 4'd10: cos_q14 = -16'sd11585;
      4'd7, 4'd9: cos_q14 = -16'sd15137;
      4'd8: cos_q14 = -16'sd16384;
      default: cos_q14 = 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sin_q14(input logic [SEC_BITS-1:0] k);
    sin_q14 = cos_q14(SEC_BITS'(k - 4'd4));
  endfunction

  function automatic logic [15:0] atan_turn(input logic [STEP_BITS-1:0] i);
    case (i)
      4'd0: atan_turn = 16'd8192;
      4'd1: atan_turn = 16'd4836;
      4'd2: atan_turn = 16'd2555;
      4'd3: atan_turn = 16'd1297;
      4'd4: atan_turn = 16'd651;
      4'd5: atan_turn = 16'd326;
      4'd6: atan_turn = 16'd163;
      4'd7: atan_turn = 16'd81;
      4'd8: atan_turn = 16'd41;
      4'd9: atan_turn = 16'd20;
      4'd10: atan_turn = 16'd10;
      4'd11: atan_turn = 16'd5;
      4'd12, 4'd13: atan_turn = 16'd3 - 16'(i == 4'd13) * 16'd2;
      4'd14: atan_turn = 16'd1;
      default: atan_turn = 16'd0;
    endcase
  endfunction
endpackage

[rtl/wind_vane_vector_averager_unit.sv]
// Wind vane vector averager: one word per sample or readout, one result word each.
// A sample word (action 0) decodes the 12-bit vane reading to one of 16 compass
// sectors and, on a hit, adds that sector's Q1.14 unit vector to saturating cosine
// and sine sums; its result word is valid on the cycle after acceptance, and the
// input stalls while it waits. A readout word (action 1) returns the mean
// direction in tenths of a degree (0..3599) and the count, and clears the sums
// as it is accepted. The readout runs an iterative CORDIC: the sums are doubled
// one bit per cycle until the larger reaches 2^46, then a step folds the left
// half plane, then come sixteen one-step rotations, a scale state and an output
// state. An empty readout answers on the next cycle. One word is in flight at
// a time.
// Depends on wvva_pkg, wvva_accum and wvva_cordic.
module wind_vane_vector_averager_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [11:0] in_adc_raw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sample_accepted,
  output logic [11:0] out_direction_tenths,
  output logic [15:0] out_reading_count,
  output logic        out_readout_valid
);
  import wvva_pkg::*;

  logic busy_r, busy_nxt;
  logic ov_r, ov_nxt;
  logic acc_r, acc_nxt, rv_r, rv_nxt;
  logic [11:0] dir_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic take, add_en, clr_en, hit, done, start;
  sum_t cs, ss;
  count_t count;

  // hold new words while a readout runs or a result waits
  assign in_stall = busy_r || ov_r;
  assign take = in_valid && !in_stall;
  assign add_en = take && (in_action == ACT_SAMPLE);
  // a readout with data launches the arctangent; sums are cleared as it starts
  assign start = take && (in_action == ACT_READOUT) && (count != '0);
  assign clr_en = take && (in_action == ACT_READOUT);

  wvva_accum u_accum (
    .clk, .rst_n, .add_en, .clr_en, .adc_raw(in_adc_raw),
    .hit, .cos_sum(cs), .sin_sum(ss), .count
  );

  wvva_cordic u_cordic (
    .clk, .rst_n, .start, .x_in(cs), .y_in(ss), .done, .tenths(dir_nxt)
  );

  always_comb begin
    busy_nxt = busy_r;
    ov_nxt = ov_r && out_stall;
    acc_nxt = acc_r;
    rv_nxt = rv_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (in_action == ACT_SAMPLE) begin
        ov_nxt = 1'b1;
        acc_nxt = hit;
        rv_nxt = 1'b0;
        cnt_nxt = '0;
      end else if (count == '0) begin
        // empty window: answer at once with zeros
        ov_nxt = 1'b1;
        acc_nxt = 1'b0;
        rv_nxt = 1'b0;
        cnt_nxt = '0;
      end else begin
        busy_nxt = 1'b1;
        acc_nxt = 1'b0;
        rv_nxt = 1'b1;
        cnt_nxt = 16'(count);
      end
    end
    if (done) begin
      busy_nxt = 1'b0;
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
    end
    acc_r <= acc_nxt;
    rv_r <= rv_nxt;
    cnt_r <= cnt_nxt;
  end

  assign out_valid = ov_r;
  assign out_sample_accepted = acc_r;
  assign out_direction_tenths = rv_r ? dir_nxt : 12'd0;
  assign out_reading_count = cnt_r;
  assign out_readout_valid = rv_r;

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && ov_r)) else $error("result while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r) else $error("stray done");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(acc_r && rv_r)) else $error("both result kinds set");
endmodule

[rtl/wvva_accum.sv]
// Sector decode and saturating vector sums for the wind vane averager.
// Depends on wvva_pkg.
module wvva_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              add_en,
  input  logic              clr_en,
  input  logic [11:0]       adc_raw,
  output logic              hit,
  output wvva_pkg::sum_t    cos_sum,
  output wvva_pkg::sum_t    sin_sum,
  output wvva_pkg::count_t  count
);
  import wvva_pkg::*;

  sum_t   cos_r, cos_nxt, sin_r, sin_nxt;
  count_t cnt_r, cnt_nxt;
  decode_t dec;

  function automatic sum_t sat_add(input sum_t a, input logic signed [15:0] b);
    logic signed [SUM_BITS:0] r;
    r = {a[SUM_BITS-1], a} + (SUM_BITS+1)'(b);
    if (r[SUM_BITS] != r[SUM_BITS-1])
      sat_add = r[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    else
      sat_add = r[SUM_BITS-1:0];
  endfunction

  assign dec = decode_vane(adc_raw);
  assign hit = dec.hit && (cnt_r != {COUNT_BITS{1'b1}});

  always_comb begin
    cos_nxt = cos_r;
    sin_nxt = sin_r;
    cnt_nxt = cnt_r;
    if (clr_en) begin
      cos_nxt = '0;
      sin_nxt = '0;
      cnt_nxt = '0;
    end else if (add_en && hit) begin
      cos_nxt = sat_add(cos_r, cos_q14(dec.sector));
      sin_nxt = sat_add(sin_r, sin_q14(dec.sector));
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= '0;
      sin_r <= '0;
      cnt_r <= '0;
    end else begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign cos_sum = cos_r;
  assign sin_sum = sin_r;
  assign count = cnt_r;

  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |=> (cnt_r == '0 && cos_r == '0 && sin_r == '0))
    else $error("sums not cleared");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (add_en && !clr_en && !hit) |=> $stable(cnt_r))
    else $error("rejected sample counted");
  a_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (add_en && !clr_en && hit) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("accepted sample not counted");
endmodule

[rtl/wvva_cordic.sv]
// Iterative vectoring CORDIC: normalize, sixteen rotations, scale to tenths.
// Depends on wvva_pkg.
module wvva_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  wvva_pkg::sum_t    x_in,
  input  wvva_pkg::sum_t    y_in,
  output logic              done,
  output logic [11:0]       tenths
);
  import wvva_pkg::*;

  state_t st_r, st_nxt;
  cw_t x_r, x_nxt, y_r, y_nxt;
  logic [15:0] ang_r, ang_nxt;
  logic [STEP_BITS-1:0] i_r, i_nxt;
  logic [11:0] ten_r, ten_nxt;
  logic [27:0] prod;
  logic [11:0] t;
  logic big;

  assign big = (x_r[CW-1:NORM_EXP] != {(CW-NORM_EXP){x_r[CW-1]}}) ||
               (y_r[CW-1:NORM_EXP] != {(CW-NORM_EXP){y_r[CW-1]}}) ||
               (x_r == -(cw_t'(1) <<< NORM_EXP)) || (y_r == -(cw_t'(1) <<< NORM_EXP));
  assign prod = 28'(ang_r) * 28'd3600 + 28'd32768;
  assign t = prod[28-1:16];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (start) st_nxt = ST_NORM;
      ST_NORM:  if (big || (x_r == '0 && y_r == '0)) st_nxt = ST_ROT;
      ST_ROT:   if (i_r == STEP_BITS'(STEPS-1)) st_nxt = ST_SCALE;
      ST_SCALE: st_nxt = ST_OUT;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    ang_nxt = ang_r;
    i_nxt = i_r;
    ten_nxt = ten_r;
    case (st_r)
      ST_IDLE: begin
        x_nxt = CW'(x_in);
        y_nxt = CW'(y_in);
        ang_nxt = '0;
        i_nxt = '0;
      end
      ST_NORM: begin
        if (x_r == '0 && y_r == '0) begin
          ang_nxt = '0;
        end else if (!big) begin
          // double both until the larger magnitude reaches 2^46
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else if (x_r < 0) begin
          x_nxt = -x_r;
          y_nxt = -y_r;
          ang_nxt = 16'd32768;
        end
      end
      ST_ROT: begin
        if (x_r == '0 && y_r == '0) begin
          ang_nxt = '0;
        end else if (!y_r[CW-1]) begin
          x_nxt = x_r + (y_r >>> i_r);
          y_nxt = y_r - (x_r >>> i_r);
          ang_nxt = ang_r + atan_turn(i_r);
        end else begin
          x_nxt = x_r - (y_r >>> i_r);
          y_nxt = y_r + (x_r >>> i_r);
          ang_nxt = ang_r - atan_turn(i_r);
        end
        i_nxt = i_r + 1'b1;
      end
      ST_SCALE: ten_nxt = (t >= 12'd3600) ? 12'd0 : t;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    ang_r <= ang_nxt;
    i_r <= i_nxt;
    ten_r <= ten_nxt;
  end

  assign done = (st_r == ST_OUT);
  assign tenths = ten_r;

  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ten_r < 12'd3600) else $error("tenths out of range");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCALE) |=> done) else $error("scale not followed by output");
  a_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROT && i_r != STEP_BITS'(STEPS-1)) |=> st_r == ST_ROT)
    else $error("rotation cut short");
endmodule
